// ===== rtl/trcl_pkg.sv =====
// Shared types and constants of the tilt ratio color lookup.
package trcl_pkg;

  // One color table row.
  typedef struct packed {
    logic [15:0] threshold;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } row_t;

  // Request kinds.
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Quadrant table selects, one per quadrant 1 to 4.
  localparam logic [1:0] QUAD_1 = 2'd0;
  localparam logic [1:0] QUAD_2 = 2'd1;
  localparam logic [1:0] QUAD_3 = 2'd2;
  localparam logic [1:0] QUAD_4 = 2'd3;

  // Ratio arithmetic.
  localparam int RATIO_SHIFT = 9;
  localparam int MAG_W       = 17;
  localparam int RATIO_W     = 25;
  localparam int DIV_CNT_W   = 5;
  localparam logic [RATIO_W-1:0] NO_X_RATIO = 25'd50000;

endpackage

// ===== rtl/trcl_divider.sv =====
// Radix-2 restoring divider that produces one quotient bit per cycle.
module trcl_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [trcl_pkg::RATIO_W-1:0]   dividend,
  input  logic [trcl_pkg::MAG_W-1:0]     divisor,
  output logic                           done,
  output logic [trcl_pkg::RATIO_W-1:0]   quotient
);

  localparam logic [trcl_pkg::DIV_CNT_W-1:0] LAST_STEP =
    trcl_pkg::DIV_CNT_W'(trcl_pkg::RATIO_W - 1);

  logic                            run_r;
  logic                            done_r;
  logic [trcl_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [trcl_pkg::MAG_W-1:0]      rem_r;
  logic [trcl_pkg::MAG_W-1:0]      divisor_r;
  logic [trcl_pkg::RATIO_W-1:0]    quo_r;

  logic [trcl_pkg::MAG_W:0]        trial;
  logic                            fits;
  logic [trcl_pkg::MAG_W-1:0]      rem_nxt;

  // The remainder stays below the divisor, so the shifted trial fits one extra bit.
  always_comb begin
    trial   = {rem_r, quo_r[trcl_pkg::RATIO_W-1]};
    fits    = (trial >= {1'b0, divisor_r});
    rem_nxt = fits ? trcl_pkg::MAG_W'(trial - {1'b0, divisor_r})
                   : trial[trcl_pkg::MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r     <= '0;
      quo_r     <= dividend;
      divisor_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[trcl_pkg::RATIO_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/trcl_table.sv =====
// Color table memory with one write port and one registered read port.
module trcl_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  trcl_pkg::row_t      wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output trcl_pkg::row_t      rd_data
);

  trcl_pkg::row_t table_mem [DEPTH];
  trcl_pkg::row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= table_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tilt_ratio_color_lookup_core.sv =====
// Top level of the tilt ratio color lookup: request control, ratio and table walk.
//
//   Channel  | Handshake            | Payload
//   ---------+----------------------+-----------------------------------------------
//   in_      | start, busy          | mode, x/y acceleration, one table row to load
//   out_     | out_valid (strobe)   | color, tilt ratio, quadrant number, row chosen
//
// A load request writes its row at the edge that accepts it.
// A sample request with nonzero x runs the serial divider, then walks its quadrant's
// table at one row per cycle through the registered memory read port; with x equal
// to zero the divide is skipped.
// busy is high from acceptance of a sample until its result strobe; the result is
// shown for exactly one cycle and the receiver cannot hold it off.
// Reset is synchronous and clears control state only; table rows are undefined
// until loaded, and there is no clearing pass.
module tilt_ratio_color_lookup_core #(
  parameter int TABLE_ROWS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [15:0] in_x_accel,
  input  logic signed [15:0] in_y_accel,
  input  logic [1:0]         in_load_quadrant,
  input  logic [3:0]         in_load_row,
  input  logic [15:0]        in_load_threshold,
  input  logic [7:0]         in_load_red,
  input  logic [7:0]         in_load_green,
  input  logic [7:0]         in_load_blue,
  output logic               out_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [24:0]        out_tilt_ratio,
  output logic [2:0]         out_quadrant_number,
  output logic [3:0]         out_row_chosen
);

  localparam int DEPTH = 4 * TABLE_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(TABLE_ROWS);
  localparam logic [AW-1:0] ROWS_A   = AW'(TABLE_ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(TABLE_ROWS - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_WALK  = 4'b1000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [1:0]                      quad_r, quad_nxt;
  logic [trcl_pkg::RATIO_W-1:0]    ratio_r, ratio_nxt;
  logic [RW-1:0]                   k_r, k_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      red_r, green_r, blue_r;
  logic [trcl_pkg::RATIO_W-1:0]    ratio_out_r;
  logic [2:0]                      quad_out_r;
  logic [3:0]                      row_out_r;

  logic                            accept;
  logic                            x_neg, y_neg;
  logic [trcl_pkg::MAG_W-1:0]      ax, ay;
  logic [1:0]                      quad_in;
  logic                            load_ok;

  logic                            div_start;
  logic                            div_done;
  logic [trcl_pkg::RATIO_W-1:0]    div_quotient;
  logic [trcl_pkg::RATIO_W-1:0]    dividend;

  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  trcl_pkg::row_t                  wr_data;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  trcl_pkg::row_t                  rd_data;

  logic [AW-1:0]                   base;
  logic                            advance;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Magnitudes of the 16-bit samples; the most negative value maps to 32768.
  assign x_neg = in_x_accel[15];
  assign y_neg = in_y_accel[15];
  assign ax = x_neg ? (17'd0 - {1'b1, in_x_accel}) : {1'b0, in_x_accel};
  assign ay = y_neg ? (17'd0 - {1'b1, in_y_accel}) : {1'b0, in_y_accel};
  // |y| is at most 2^15, so the shifted dividend fits in 25 bits.
  assign dividend = trcl_pkg::RATIO_W'({ay, {trcl_pkg::RATIO_SHIFT{1'b0}}});

  // A zero x counts as nonnegative, which puts the vector in quadrant 1 or 4.
  always_comb begin
    case ({x_neg, y_neg})
      2'b00:   quad_in = trcl_pkg::QUAD_1;
      2'b10:   quad_in = trcl_pkg::QUAD_2;
      2'b11:   quad_in = trcl_pkg::QUAD_3;
      default: quad_in = trcl_pkg::QUAD_4;
    endcase
  end

  // Loads aimed past the last row are dropped without a write.
  assign load_ok = ({28'd0, in_load_row} < 32'(TABLE_ROWS));
  assign wr_en   = accept && (in_mode == trcl_pkg::MODE_LOAD) && load_ok;
  assign wr_addr = AW'(in_load_quadrant) * ROWS_A + AW'(in_load_row);
  assign wr_data = '{threshold: in_load_threshold, red: in_load_red,
                     green: in_load_green, blue: in_load_blue};

  assign div_start = accept && (in_mode == trcl_pkg::MODE_SAMPLE) && (ax != '0);

  assign base = AW'(quad_r) * ROWS_A;

  // In the walk, rd_data holds row k_r. The walk moves on while that row's
  // threshold is strictly below the ratio and a further row exists.
  assign advance = ({9'd0, rd_data.threshold} < ratio_r) && (k_r != LAST_ROW);

  always_comb begin
    state_nxt     = state_r;
    quad_nxt      = quad_r;
    ratio_nxt     = ratio_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = base;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == trcl_pkg::MODE_SAMPLE)) begin
          quad_nxt = quad_in;
          if (ax == '0) begin
            ratio_nxt = trcl_pkg::NO_X_RATIO;
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ratio_nxt = div_quotient;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        rd_en     = 1'b1;
        rd_addr   = base;
        k_nxt     = '0;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (advance) begin
          rd_en   = 1'b1;
          rd_addr = base + AW'(k_r + RW'(1));
          k_nxt   = k_r + RW'(1);
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and result registers carry no reset.
  always_ff @(posedge clk) begin
    quad_r  <= quad_nxt;
    ratio_r <= ratio_nxt;
    k_r     <= k_nxt;
    if (out_valid_nxt) begin
      red_r       <= rd_data.red;
      green_r     <= rd_data.green;
      blue_r      <= rd_data.blue;
      ratio_out_r <= ratio_r;
      quad_out_r  <= 3'(quad_r) + 3'd1;
      row_out_r   <= 4'(k_r);
    end
  end

  trcl_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (ax),
    .done     (div_done),
    .quotient (div_quotient)
  );

  trcl_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid           = out_valid_r;
  assign out_red             = red_r;
  assign out_green           = green_r;
  assign out_blue            = blue_r;
  assign out_tilt_ratio      = ratio_out_r;
  assign out_quadrant_number = quad_out_r;
  assign out_row_chosen      = row_out_r;

  // A result strobe only ever follows the last cycle of a table walk.
  a_strobe_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_WALK))
    else $error("result strobe without a finished walk");

  // The divider reports completion only while the control waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // The table is never written while a sample is in flight.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !wr_en)
    else $error("table write while busy");

  // Each walk step reads exactly the next row of the same quadrant.
  a_walk_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && advance) |=> (state_r == ST_WALK && k_r == $past(k_r) + RW'(1)))
    else $error("table walk skipped a row");

endmodule

// ===== verif/trcl_checker.sv =====
// Checker for the tilt ratio color lookup: keeps its own color tables, predicts and compares.
module trcl_checker #(
  parameter int TABLE_ROWS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_mode,
  input  logic signed [15:0] in_x_accel,
  input  logic signed [15:0] in_y_accel,
  input  logic [1:0]         in_load_quadrant,
  input  logic [3:0]         in_load_row,
  input  logic [15:0]        in_load_threshold,
  input  logic [7:0]         in_load_red,
  input  logic [7:0]         in_load_green,
  input  logic [7:0]         in_load_blue,
  input  logic               out_valid,
  input  logic [7:0]         out_red,
  input  logic [7:0]         out_green,
  input  logic [7:0]         out_blue,
  input  logic [24:0]        out_tilt_ratio,
  input  logic [2:0]         out_quadrant_number,
  input  logic [3:0]         out_row_chosen,
  output int unsigned        fault_count,
  output int unsigned        awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]                   red;
    logic [7:0]                   green;
    logic [7:0]                   blue;
    logic [trcl_pkg::RATIO_W-1:0] ratio;
    logic [2:0]                   quadrant;
    logic [3:0]                   row;
  } color_answer_t;

  trcl_pkg::row_t color_rows [4*TABLE_ROWS];
  color_answer_t  pending_colors [$];
  int unsigned    faults = 0;

  // Ratio, quadrant and table walk for one acceleration reading.
  function automatic color_answer_t predict_color(logic signed [15:0] x, logic signed [15:0] y);
    logic [trcl_pkg::MAG_W-1:0] mag_x;
    logic [trcl_pkg::MAG_W-1:0] mag_y;
    logic [25:0]                ratio;
    logic [1:0]                 quad_sel;
    int                         walk;
    int                         slot;
    color_answer_t              ans;
    mag_x = x[15] ? (17'h10000 - {1'b0, x}) : {1'b0, x};
    mag_y = y[15] ? (17'h10000 - {1'b0, y}) : {1'b0, y};
    if (mag_x == '0) begin
      ratio = 26'(trcl_pkg::NO_X_RATIO);
    end else begin
      ratio = (26'(mag_y) << trcl_pkg::RATIO_SHIFT) / 26'(mag_x);
    end
    if (!x[15]) begin
      quad_sel = y[15] ? trcl_pkg::QUAD_4 : trcl_pkg::QUAD_1;
    end else begin
      quad_sel = y[15] ? trcl_pkg::QUAD_3 : trcl_pkg::QUAD_2;
    end
    walk = 0;
    while (walk + 1 < TABLE_ROWS &&
           26'(color_rows[int'(quad_sel) * TABLE_ROWS + walk].threshold) < ratio) begin
      walk++;
    end
    slot = int'(quad_sel) * TABLE_ROWS + walk;
    ans.red      = color_rows[slot].red;
    ans.green    = color_rows[slot].green;
    ans.blue     = color_rows[slot].blue;
    ans.ratio    = ratio[trcl_pkg::RATIO_W-1:0];
    ans.quadrant = 3'(quad_sel) + 3'd1;
    ans.row      = 4'(walk);
    return ans;
  endfunction

  task automatic log_fault(string what);
    faults++;
    if (faults <= 10) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    color_answer_t want;
    if (!rst_n) begin
      pending_colors.delete();
    end else begin
      if (out_valid) begin
        if (pending_colors.size() == 0) begin
          log_fault("result strobe with no sample request outstanding");
        end else begin
          want = pending_colors.pop_front();
          if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue ||
              out_tilt_ratio !== want.ratio || out_quadrant_number !== want.quadrant ||
              out_row_chosen !== want.row) begin
            log_fault($sformatf({"mismatch: expected rgb %02h/%02h/%02h ratio %0d quad %0d ",
                                 "row %0d, got rgb %02h/%02h/%02h ratio %0d quad %0d row %0d"},
                                want.red, want.green, want.blue, want.ratio, want.quadrant,
                                want.row, out_red, out_green, out_blue, out_tilt_ratio,
                                out_quadrant_number, out_row_chosen));
          end
        end
      end
      if (start && !busy) begin
        if (in_mode == trcl_pkg::MODE_LOAD) begin
          if (int'(in_load_row) < TABLE_ROWS) begin
            color_rows[int'(in_load_quadrant) * TABLE_ROWS + int'(in_load_row)] =
              '{in_load_threshold, in_load_red, in_load_green, in_load_blue};
          end
        end else begin
          pending_colors.push_back(predict_color(in_x_accel, in_y_accel));
        end
      end
    end
    awaiting    <= pending_colors.size();
    fault_count <= faults;
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the tilt ratio color lookup testbench: clock, reset, request stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is cut off here.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          RANDOM_ITEMS = 970;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_mode = trcl_pkg::MODE_LOAD;
  logic signed [15:0] in_x_accel = '0;
  logic signed [15:0] in_y_accel = '0;
  logic [1:0]         in_load_quadrant = trcl_pkg::QUAD_1;
  logic [3:0]         in_load_row = '0;
  logic [15:0]        in_load_threshold = '0;
  logic [7:0]         in_load_red = '0;
  logic [7:0]         in_load_green = '0;
  logic [7:0]         in_load_blue = '0;
  logic               out_valid;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [24:0]        out_tilt_ratio;
  logic [2:0]         out_quadrant_number;
  logic [3:0]         out_row_chosen;

  int unsigned fault_count;
  int unsigned awaiting;
  int unsigned cycle_count = 0;
  int unsigned load_count = 0;
  int unsigned reading_count = 0;
  int unsigned zero_x_count = 0;
  int unsigned drain_count = 0;
  int unsigned burst_left = 0;

  always #10 clk = ~clk;

  tilt_ratio_color_lookup_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_x_accel          (in_x_accel),
    .in_y_accel          (in_y_accel),
    .in_load_quadrant    (in_load_quadrant),
    .in_load_row         (in_load_row),
    .in_load_threshold   (in_load_threshold),
    .in_load_red         (in_load_red),
    .in_load_green       (in_load_green),
    .in_load_blue        (in_load_blue),
    .out_valid           (out_valid),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .out_tilt_ratio      (out_tilt_ratio),
    .out_quadrant_number (out_quadrant_number),
    .out_row_chosen      (out_row_chosen)
  );

  // The checker watches both channels beside the block and reports back only a
  // failure count and the number of sample requests still waiting for a result.
  trcl_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_mode             (in_mode),
    .in_x_accel          (in_x_accel),
    .in_y_accel          (in_y_accel),
    .in_load_quadrant    (in_load_quadrant),
    .in_load_row         (in_load_row),
    .in_load_threshold   (in_load_threshold),
    .in_load_red         (in_load_red),
    .in_load_green       (in_load_green),
    .in_load_blue        (in_load_blue),
    .out_valid           (out_valid),
    .out_red             (out_red),
    .out_green           (out_green),
    .out_blue            (out_blue),
    .out_tilt_ratio      (out_tilt_ratio),
    .out_quadrant_number (out_quadrant_number),
    .out_row_chosen      (out_row_chosen),
    .fault_count         (fault_count),
    .awaiting            (awaiting)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycle_count, awaiting);
      $display("** tilt_ratio_color_lookup_core: FAILED **");
      $finish;
    end
  end

  // Turns a magnitude and a sign into a 16-bit reading. A positive magnitude of
  // 32768 cannot be shown, so it is clipped to 32767.
  function automatic logic signed [15:0] signed_reading(int unsigned mag, bit neg);
    if (neg) begin
      return 16'(-int'(mag));
    end
    return (mag > 32767) ? 16'sd32767 : 16'(mag);
  endfunction

  // Most rows get a threshold on a rising ramp, so a quadrant's thresholds
  // usually climb with the row number and the walk can stop anywhere. Now and
  // then a row gets any value, which breaks the ordering on purpose.
  function automatic logic [15:0] pick_threshold(logic [3:0] row);
    if ($urandom_range(0, 4) == 0) begin
      return 16'($urandom);
    end
    return 16'(int'(row) * 4096 + $urandom_range(0, 4095));
  endfunction

  // Idle time before the next request: mostly none or a few cycles, rarely a
  // long pause, and now and then a burst of back-to-back requests.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 3) begin
      burst_left = 20;
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one request and holds it until an edge sees start high with busy
  // low. Unless an idle gap is picked, start stays high on return, so a request that
  // follows at once keeps it high without a second assignment in the same step.
  task automatic send_request(logic mode, logic signed [15:0] x, logic signed [15:0] y,
                              logic [1:0] quad_sel, logic [3:0] row, logic [15:0] threshold,
                              logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    int unsigned gap;
    in_mode           <= mode;
    in_x_accel        <= x;
    in_y_accel        <= y;
    in_load_quadrant  <= quad_sel;
    in_load_row       <= row;
    in_load_threshold <= threshold;
    in_load_red       <= red;
    in_load_green     <= green;
    in_load_blue      <= blue;
    start             <= 1'b1;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A table row load; the acceleration ports carry random values the block must ignore.
  task automatic send_load(logic [1:0] quad_sel, logic [3:0] row, logic [15:0] threshold,
                           logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    load_count++;
    send_request(trcl_pkg::MODE_LOAD, 16'($urandom), 16'($urandom), quad_sel, row,
                 threshold, red, green, blue);
  endtask

  // A sample request; the load ports carry random values the block must ignore.
  task automatic send_reading(logic signed [15:0] x, logic signed [15:0] y);
    reading_count++;
    if (x == 0) zero_x_count++;
    send_request(trcl_pkg::MODE_SAMPLE, x, y, 2'($urandom), 4'($urandom), 16'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic random_load();
    logic [3:0] row;
    row = 4'($urandom);
    send_load(2'($urandom), row, pick_threshold(row),
              8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Random sample. A third are raw readings, which mostly give small ratios;
  // a few have x at zero; the rest aim at a chosen ratio so that walks end
  // on every row, including the last one.
  task automatic random_reading();
    int unsigned roll;
    int unsigned target;
    int unsigned mag_x;
    int unsigned mag_y;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      send_reading(16'($urandom), 16'($urandom));
    end else if (roll < 45) begin
      send_reading('0, 16'($urandom));
    end else begin
      target = $urandom_range(0, 70000);
      mag_x  = $urandom_range(1, 512);
      mag_y  = (target * mag_x) >> trcl_pkg::RATIO_SHIFT;
      if (mag_y > 32768) mag_y = 32768;
      send_reading(signed_reading(mag_x, 1'($urandom_range(0, 1))),
                   signed_reading(mag_y, 1'($urandom_range(0, 1))));
    end
  endtask

  // Stops sending and waits until every sample request has had its result.
  // The first edge lets the count catch up with a request accepted just now.
  task automatic drain_results();
    drain_count++;
    start <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every row of every quadrant is loaded first, so no walk can ever reach a
    // row that holds nothing yet.
    for (int q = 0; q < 4; q++) begin
      for (int r = 0; r < 16; r++) begin
        send_load(2'(q), 4'(r), pick_threshold(4'(r)),
                  8'($urandom), 8'($urandom), 8'($urandom));
      end
    end

    // Directed part. Extreme row values: the lowest threshold with full
    // colors in quadrant 1, the highest threshold with dark colors in the last
    // row of quadrant 4.
    send_load(trcl_pkg::QUAD_1, 4'd0, 16'h0000, 8'hff, 8'hff, 8'hff);
    send_load(trcl_pkg::QUAD_4, 4'd15, 16'hffff, 8'h00, 8'h00, 8'h00);
    // A threshold equal to the ratio does not let the walk pass; one below does.
    send_load(trcl_pkg::QUAD_2, 4'd0, 16'd512, 8'h5a, 8'ha5, 8'h3c);
    send_reading(-16'sd1, 16'sd1);
    send_load(trcl_pkg::QUAD_2, 4'd0, 16'd511, 8'hc3, 8'h0f, 8'hf0);
    send_reading(-16'sd1, 16'sd1);
    // Zero x gives the fixed ratio; the quadrant still follows the y sign.
    send_reading(16'sd0, 16'sd0);
    send_reading(16'sd0, -16'sd32768);
    // Most negative readings, largest and smallest ratios, truncation.
    send_reading(-16'sd32768, -16'sd32768);
    send_reading(16'sd1, -16'sd32768);
    send_reading(-16'sd1, 16'sd32767);
    send_reading(16'sd32767, 16'sd0);
    send_reading(-16'sd32768, 16'sd0);
    send_reading(16'sd32767, 16'sd32767);
    send_reading(16'sd3, 16'sd1);
    send_reading(-16'sd32768, 16'sd32767);
    send_reading(16'sd1, 16'sd32767);
    drain_results();

    // Random part: roughly one load for every two samples, so the tables keep
    // changing underneath the walks. The sender stops until all results are
    // in once halfway through and at a few random points besides.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        random_load();
      end else begin
        random_reading();
      end
      if (i == RANDOM_ITEMS / 2 || $urandom_range(0, 199) == 0) begin
        drain_results();
      end
    end

    drain_results();
    // A stray result would show up within a walk's length of cycles.
    repeat (60) @(posedge clk);

    $display("Run covered %0d table row loads and %0d samples (%0d with x at zero),",
             load_count, reading_count, zero_x_count);
    $display("with %0d full drains of the result stream, in %0d cycles.",
             drain_count, cycle_count);
    if (fault_count == 0 && awaiting == 0) begin
      $display("** tilt_ratio_color_lookup_core: PASSED **");
    end else begin
      $display("%0d failures, %0d results missing", fault_count, awaiting);
      $display("** tilt_ratio_color_lookup_core: FAILED **");
    end
    $finish;
  end

endmodule
